// ----- design/cba_pkg.sv -----
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants of the cluster bitmap allocator
// Operation and status codes, fixed field widths and the control and status
// structs that pass between the sequencer and the freed-cluster queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  localparam int CL_W  = 16;  // cluster number
  localparam int CNT_W = 17;  // cluster count register
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [ST_W-1:0] ST_Q_OVF   = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

  localparam logic [CNT_W-1:0] COUNT_RESET = 17'h10000;
  localparam logic [CNT_W-1:0] COUNT_MIN   = 17'd2;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

`default_nettype wire

// ----- design/cba_if.sv -----
// ----------------------------------------------------------------------------
// cba_if: valid/ready channels of the cluster bitmap allocator
// Configuration write channel, command channel and response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cba_cfg_if import cba_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cba_cmd_if import cba_pkg::*;;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [CL_W-1:0] cluster;

  modport source (output valid, output op, output cluster, input ready);
  modport sink   (input valid, input op, input cluster, output ready);
endinterface

interface cba_rsp_if import cba_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CL_W-1:0] result_cluster;
  logic [ST_W-1:0] status;

  modport source (output valid, output result_cluster, output status, input ready);
  modport sink   (input valid, input result_cluster, input status, output ready);
endinterface

`default_nettype wire

// ----- design/cluster_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// cluster_bitmap_allocator: free-cluster manager for a disk partition
// Bitmap of free clusters, queue of freed clusters and a forward scan pointer,
// driven by a small sequencer that works one bitmap word per step.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload
//   cfg      in   data: cluster_count
//   cmd      in   op, cluster
//   rsp      out  result_cluster, status
//
// One command at a time; cmd.ready is high only when the sequencer is idle.
// Free: range check, bitmap read, bit set and queue push; out of range, and for
// an unused op, straight to the response. Allocate from the queue: head read,
// word index folded into the bitmap by repeated subtraction, bitmap read, bit
// clear. Allocate by scan: each bitmap word visited is read and checked (one
// port), then the word is searched on after a take below bit 31. Format: root
// by repeated addition, then the sweep, one word a cycle. The bitmap needs no
// clearing after reset; format must be issued before the first allocate or
// free. A finished response waits in its register while the next command runs.
// ----------------------------------------------------------------------------
`default_nettype none

module cluster_bitmap_allocator import cba_pkg::*; #(
  parameter int MAX_CLUSTERS         = 65536,
  parameter int BITS_PER_MAP_CLUSTER = 16384,
  parameter int FREE_QUEUE_DEPTH     = 256
) (
  input  logic      clk,
  input  logic      rst,
  cba_cfg_if.sink   cfg,
  cba_cmd_if.sink   cmd,
  cba_rsp_if.source rsp
);

  localparam int MAP_WORDS = (MAX_CLUSTERS + 31) / 32;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = WIDX_W + 5;
  localparam int PTR_W     = CNT_W + 1;
  localparam int CMP_W     = (CW > PTR_W) ? CW : PTR_W;
  localparam int QW        = CL_W - 5;
  localparam int MAX_EFF   = (MAX_CLUSTERS < (2 ** CNT_W - 1)) ?
                             MAX_CLUSTERS : (2 ** CNT_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FCHK, S_FWAIT, S_FDAT, S_QWAIT, S_QDAT, S_QMOD, S_MWAIT,
    S_MCLR, S_SRD, S_SWAIT, S_SCHK, S_ROOT, S_FMT, S_RESP
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cluster_count;
  logic [CNT_W-1:0]  count;
  logic [CL_W-1:0]   cl_r;
  logic [WIDX_W-1:0] maddr;
  logic [WIDX_W-1:0] sweep;
  logic [QW-1:0]     widx;
  logic [4:0]        bitsel;
  logic [PTR_W-1:0]  scan_pointer;
  logic              phase;
  logic              use_buf;
  logic [31:0]       wbuf;
  logic [CNT_W-1:0]  root;
  logic [PTR_W-1:0]  acc;
  logic [CL_W-1:0]   res_r;
  logic [ST_W-1:0]   st_r;
  logic              rsp_valid;
  logic [CL_W-1:0]   rsp_cluster;
  logic [ST_W-1:0]   rsp_status;

  logic              map_we;
  logic [WIDX_W-1:0] map_waddr;
  logic [31:0]       map_wdata;
  logic [31:0]       map_rdata;

  fifo_ctl_t         q_ctl;
  fifo_sts_t         q_sts;
  logic [CL_W-1:0]   q_rdata;

  logic [31:0]       src_word;
  logic              hit;
  logic [4:0]        hit_j;
  logic [PTR_W-1:0]  cand;
  logic [PTR_W-1:0]  next_base;
  logic [31:0]       fmt_word;
  logic [PTR_W-1:0]  root_inc;

  cba_map_ram #(
    .WORDS (MAP_WORDS),
    .AW    (WIDX_W)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (maddr),
    .rdata (map_rdata)
  );

  cba_fifo #(
    .DEPTH (FREE_QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctl   (q_ctl),
    .wdata (cl_r),
    .sts   (q_sts),
    .rdata (q_rdata)
  );

  assign cfg.ready          = 1'b1;
  assign cmd.ready          = (state == S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.result_cluster = rsp_cluster;
  assign rsp.status         = rsp_status;

  // clamp the register into the legal range
  always_comb begin
    if (cluster_count < COUNT_MIN) begin
      count = COUNT_MIN;
    end else if (cluster_count > CNT_W'(MAX_EFF)) begin
      count = CNT_W'(MAX_EFF);
    end else begin
      count = cluster_count;
    end
  end

  // first free bit of the current word at or after the scan pointer
  always_comb begin
    logic [PTR_W-1:0] c;
    src_word = use_buf ? wbuf : map_rdata;
    hit      = 1'b0;
    hit_j    = '0;
    for (int j = 31; j >= 0; j--) begin
      c = {scan_pointer[PTR_W-1:5], 5'(j)};
      if (src_word[j] && (5'(j) >= scan_pointer[4:0]) && (c < PTR_W'(count))) begin
        hit   = 1'b1;
        hit_j = 5'(j);
      end
    end
  end

  assign cand      = {scan_pointer[PTR_W-1:5], hit_j};
  assign next_base = (scan_pointer | PTR_W'(31)) + PTR_W'(1);
  assign root_inc  = PTR_W'(root) + PTR_W'(1);

  // clusters above root and below count start free
  always_comb begin
    logic [CMP_W-1:0] c;
    for (int j = 0; j < 32; j++) begin
      c = CMP_W'({sweep, 5'(j)});
      fmt_word[j] = (c > CMP_W'(root)) && (c < CMP_W'(count));
    end
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = maddr;
    map_wdata = map_rdata;
    q_ctl     = '0;
    unique case (state)
      S_FDAT: begin
        map_we     = 1'b1;
        map_wdata  = map_rdata | (32'd1 << bitsel);
        q_ctl.push = !q_sts.full;
      end
      S_QDAT: begin
        q_ctl.pop = 1'b1;
      end
      S_MCLR: begin
        map_we    = 1'b1;
        map_wdata = map_rdata & ~(32'd1 << bitsel);
      end
      S_SCHK: begin
        map_we    = hit && !phase;
        map_wdata = src_word & ~(32'd1 << hit_j);
      end
      S_FMT: begin
        map_we      = 1'b1;
        map_waddr   = sweep;
        map_wdata   = fmt_word;
        q_ctl.clear = (sweep == WIDX_W'(MAP_WORDS - 1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cluster_count <= COUNT_RESET;
      scan_pointer  <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        cluster_count <= cfg.data;
      end
      // the response state reloads the register itself
      if (rsp_valid && rsp.ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cl_r  <= cmd.cluster;
            res_r <= '0;
            st_r  <= ST_OK;
            phase <= 1'b0;
            case (cmd.op)
              OP_ALLOC:  state <= q_sts.empty ? S_SRD : S_QWAIT;
              OP_FREE:   state <= S_FCHK;
              OP_FORMAT: begin
                root  <= '0;
                acc   <= '0;
                state <= S_ROOT;
              end
              default:   state <= S_RESP;
            endcase
          end
        end

        S_FCHK: begin
          if (CNT_W'(cl_r) >= count) begin
            st_r  <= ST_RANGE;
            state <= S_RESP;
          end else begin
            maddr  <= WIDX_W'(cl_r >> 5);
            bitsel <= cl_r[4:0];
            state  <= S_FWAIT;
          end
        end

        S_FWAIT: state <= S_FDAT;

        S_FDAT: begin
          if (q_sts.full) begin
            st_r <= ST_Q_OVF;
          end
          state <= S_RESP;
        end

        S_QWAIT: state <= S_QDAT;

        S_QDAT: begin
          res_r  <= q_rdata;
          widx   <= q_rdata[CL_W-1:5];
          bitsel <= q_rdata[4:0];
          state  <= S_QMOD;
        end

        // fold the word index back into the bitmap
        S_QMOD: begin
          if (32'(widx) >= MAP_WORDS) begin
            widx <= widx - QW'(MAP_WORDS);
          end else begin
            maddr <= WIDX_W'(widx);
            state <= S_MWAIT;
          end
        end

        S_MWAIT: state <= S_MCLR;

        S_MCLR: state <= S_RESP;

        S_SRD: begin
          if (scan_pointer >= PTR_W'(count)) begin
            scan_pointer <= PTR_W'(count);
            if (!phase) begin
              st_r <= ST_NO_FREE;
            end
            state <= S_RESP;
          end else begin
            maddr   <= WIDX_W'(scan_pointer >> 5);
            use_buf <= 1'b0;
            state   <= S_SWAIT;
          end
        end

        S_SWAIT: state <= S_SCHK;

        S_SCHK: begin
          if (hit && !phase) begin
            // take this cluster, then look on for the next free one
            res_r        <= CL_W'(cand);
            wbuf         <= src_word & ~(32'd1 << hit_j);
            use_buf      <= 1'b1;
            phase        <= 1'b1;
            scan_pointer <= cand + PTR_W'(1);
            if (hit_j == 5'd31) begin
              state <= S_SRD;
            end
          end else if (hit) begin
            scan_pointer <= cand;
            state        <= S_RESP;
          end else begin
            scan_pointer <= next_base;
            state        <= S_SRD;
          end
        end

        // root = ceil(count / BITS_PER_MAP_CLUSTER) by repeated addition
        S_ROOT: begin
          if (acc < PTR_W'(count)) begin
            acc  <= acc + PTR_W'(BITS_PER_MAP_CLUSTER);
            root <= root + CNT_W'(1);
          end else begin
            sweep <= '0;
            state <= S_FMT;
          end
        end

        S_FMT: begin
          if (sweep == WIDX_W'(MAP_WORDS - 1)) begin
            scan_pointer <= (root_inc < PTR_W'(count)) ? root_inc : PTR_W'(count);
            res_r        <= CL_W'(root);
            state        <= S_RESP;
          end else begin
            sweep <= sweep + WIDX_W'(1);
          end
        end

        S_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            rsp_cluster <= res_r;
            rsp_status  <= st_r;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/cba_map_ram.sv -----
// ----------------------------------------------------------------------------
// cba_map_ram: free-cluster bitmap storage
// One word of 32 cluster bits per address, one write port and one read port
// with registered read data. Contents are undefined until formatted.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_map_ram import cba_pkg::*; #(
  parameter int WORDS = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/cba_fifo.sv -----
// ----------------------------------------------------------------------------
// cba_fifo: queue of freed cluster numbers
// Circular buffer with head, tail and fill count. The head entry is read
// every cycle into a register, so it is valid in the cycle after head settles.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_fifo import cba_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  fifo_ctl_t       ctl,
  input  logic [CL_W-1:0] wdata,
  output fifo_sts_t       sts,
  output logic [CL_W-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [CL_W-1:0] mem [DEPTH];
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [FW-1:0]   fill;

  assign sts.empty = (fill == '0);
  assign sts.full  = (fill == FW'(DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wdata;
    end
    rdata <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (ctl.push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
      end
      if (ctl.pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (ctl.push && !ctl.pop) begin
        fill <= fill + FW'(1);
      end else if (ctl.pop && !ctl.push) begin
        fill <= fill - FW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_cluster_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cluster_bitmap_allocator: self-checking bench for the cluster allocator
// Drives allocate, free, format and unused commands over several partition
// sizes and pacing modes. A bit-accurate allocator model predicts every
// response, and the monitor compares them in order, field by field.
// ----------------------------------------------------------------------------
module tb_cluster_bitmap_allocator;
  import cba_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int MAX_CL          = 65536;
  localparam int MAP_CL_BITS     = 16384;
  localparam int FQ_DEPTH        = 256;
  localparam int RANDOM_ITEMS    = 1900;
  localparam int WATCHDOG_CYCLES = 30000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {PACE_FULL, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CL_W-1:0] cluster;
  } cmd_item_t;

  typedef struct packed {
    logic [CL_W-1:0] result_cluster;
    logic [ST_W-1:0] status;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst;

  cba_cfg_if cfg_ch ();
  cba_cmd_if cmd_ch ();
  cba_rsp_if rsp_ch ();

  cluster_bitmap_allocator uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // allocator state as the block should hold it
  bit               free_bit [MAX_CL];
  logic [CL_W-1:0]  fq_mem [FQ_DEPTH];
  logic [7:0]       fq_head = '0;
  logic [7:0]       fq_tail = '0;
  logic [8:0]       fq_fill = '0;
  logic [CNT_W-1:0] scan_ptr = '0;
  logic [CNT_W-1:0] count_reg = COUNT_RESET;

  cmd_item_t pending_cmds [$];
  rsp_item_t expected_rsps [$];
  pace_t     pace = PACE_FULL;
  bit        cmd_taken = 1'b0;
  bit        cmd_busy = 1'b0;
  int        fail_count = 0;
  int        quiet_cycles = 0;

  function automatic int clamp_count(input logic [CNT_W-1:0] value);
    if (value < COUNT_MIN) return int'(COUNT_MIN);
    if (value > MAX_CL) return MAX_CL;
    return int'(value);
  endfunction

  // first free cluster at or after from, below lim; lim if none
  function automatic int next_free(input int from, input int lim);
    int c;
    c = from;
    while (c < lim && !free_bit[c]) c++;
    return c;
  endfunction

  function automatic logic [CL_W-1:0] rand_cluster(input int lo, input int hi);
    return CL_W'($urandom_range(lo, hi));
  endfunction

  function automatic void predict_response(input logic [OP_W-1:0] op,
                                           input logic [CL_W-1:0] cl);
    int lim, c, root;
    rsp_item_t r;
    lim = clamp_count(count_reg);
    r.result_cluster = '0;
    r.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        if (fq_fill != 0) begin
          r.result_cluster = fq_mem[fq_head];
          fq_head = fq_head + 1'b1;
          fq_fill = fq_fill - 1'b1;
          free_bit[r.result_cluster] = 1'b0;
        end else begin
          c = next_free(int'(scan_ptr), lim);
          if (c >= lim) begin
            scan_ptr = CNT_W'(lim);
            r.status = ST_NO_FREE;
          end else begin
            r.result_cluster = CL_W'(c);
            free_bit[c] = 1'b0;
            scan_ptr = CNT_W'(next_free(c + 1, lim));
          end
        end
      end
      OP_FREE: begin
        if (cl >= lim) begin
          r.status = ST_RANGE;
        end else begin
          free_bit[cl] = 1'b1;
          // a full queue still marks the bit, so only the scan can find it
          if (fq_fill >= FQ_DEPTH) begin
            r.status = ST_Q_OVF;
          end else begin
            fq_mem[fq_tail] = cl;
            fq_tail = fq_tail + 1'b1;
            fq_fill = fq_fill + 1'b1;
          end
        end
      end
      OP_FORMAT: begin
        root = (lim + MAP_CL_BITS - 1) / MAP_CL_BITS;
        for (c = 0; c < MAX_CL; c++) free_bit[c] = (c > root) && (c < lim);
        fq_head = '0;
        fq_tail = '0;
        fq_fill = '0;
        scan_ptr = CNT_W'(next_free((root + 1 < lim) ? root + 1 : lim, lim));
        r.result_cluster = CL_W'(root);
      end
      default: ;
    endcase
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  // command acceptance
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      predict_response(cmd_ch.op, cmd_ch.cluster);
      cmd_taken = 1'b1;
    end
  end

  // driver: hold an item until it is taken, then advance
  always @(negedge clk) begin
    if (cmd_taken) begin
      pending_cmds.delete(0);
      cmd_taken = 1'b0;
      cmd_busy = 1'b0;
    end
    if (!rst && !cmd_busy && pending_cmds.size() != 0)
      cmd_busy = !((pace == PACE_SRC_GAPS && $urandom_range(0, 99) < 55) ||
                   (pace == PACE_BOTH && $urandom_range(0, 99) < 29));
    cmd_ch.valid <= cmd_busy;
    if (cmd_busy) begin
      cmd_ch.op      <= pending_cmds[0].op;
      cmd_ch.cluster <= pending_cmds[0].cluster;
    end else begin
      cmd_ch.op      <= OP_W'($urandom_range(0, 3));
      cmd_ch.cluster <= rand_cluster(0, 65535);
    end
    rsp_ch.ready <= !rst &&
                    !((pace == PACE_SINK_STALLS && $urandom_range(0, 99) < 55) ||
                      (pace == PACE_BOTH && $urandom_range(0, 99) < 29));
  end

  // monitor
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("response with no command outstanding: result_cluster %0d, status %0d",
               rsp_ch.result_cluster, rsp_ch.status);
        fail_count++;
      end else begin
        want = expected_rsps[0];
        expected_rsps.delete(0);
        if (rsp_ch.result_cluster !== want.result_cluster) begin
          $error("result_cluster: expected %0d, got %0d",
                 want.result_cluster, rsp_ch.result_cluster);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_cmd(input logic [OP_W-1:0] op, input logic [CL_W-1:0] cl);
    cmd_item_t item;
    item.op = op;
    item.cluster = cl;
    pending_cmds.insert(pending_cmds.size(), item);
  endfunction

  function automatic logic [CL_W-1:0] pick_cluster(input int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return rand_cluster(0, lim - 1);
    if (r == 8) return CL_W'(lim - 1 + int'($urandom_range(0, 1)));
    return rand_cluster(0, 65535);
  endfunction

  // enough in-range frees to overrun the queue, then drain part of it
  function automatic int flood_free_queue(input int lim);
    int n, m, i;
    n = FQ_DEPTH + $urandom_range(1, 16);
    m = $urandom_range(4, 40);
    for (i = 0; i < n; i++) push_cmd(OP_FREE, rand_cluster(0, lim - 1));
    for (i = 0; i < m; i++) push_cmd(OP_ALLOC, rand_cluster(0, 65535));
    return n + m;
  endfunction

  function automatic int add_traffic(input int lim);
    int kind, n, i;
    kind = $urandom_range(0, 99);
    n = 1;
    if (kind < 30) begin
      n = $urandom_range(1, 24);
      for (i = 0; i < n; i++) push_cmd(OP_ALLOC, rand_cluster(0, 65535));
    end else if (kind < 55) begin
      n = $urandom_range(1, 24);
      for (i = 0; i < n; i++) push_cmd(OP_FREE, pick_cluster(lim));
    end else if (kind < 80) begin
      n = $urandom_range(2, 16);
      for (i = 0; i < n; i++)
        push_cmd($urandom_range(0, 1) ? OP_ALLOC : OP_FREE, pick_cluster(lim));
    end else if (kind < 96) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++)
        case ($urandom_range(0, 2))
          0:       push_cmd(OP_ALLOC, rand_cluster(0, 65535));
          1:       push_cmd(OP_FREE, rand_cluster(0, 65535));
          default: push_cmd(OP_UNUSED, rand_cluster(0, 65535));
        endcase
    end else if (kind < 99) begin
      push_cmd(OP_FORMAT, rand_cluster(0, 65535));
    end else begin
      n = flood_free_queue(lim);
    end
    return n;
  endfunction

  task automatic write_cluster_count(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    count_reg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || cmd_busy)
      @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0] corner_counts [12];
    logic [CNT_W-1:0] count_value;
    int phase, lim, target, added, random_items;
    corner_counts = '{17'd0, 17'd1, 17'd2, 17'd3, 17'd64, 17'd100, 17'd16384,
                      17'd16385, 17'd65535, 17'd65536, 17'd65537, 17'h1FFFF};
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // five clusters, root 1: clusters 2 to 4 start free
    write_cluster_count(17'd5);
    push_cmd(OP_FORMAT, 16'd0);
    push_cmd(OP_ALLOC, 16'd0);
    push_cmd(OP_ALLOC, 16'hFFFF);
    push_cmd(OP_ALLOC, 16'd0);
    push_cmd(OP_ALLOC, 16'd0);    // partition full
    push_cmd(OP_FREE, 16'd5);     // first number past the end
    push_cmd(OP_FREE, 16'hFFFF);
    push_cmd(OP_FREE, 16'd3);
    push_cmd(OP_FREE, 16'd3);     // freed twice, so handed out twice
    push_cmd(OP_ALLOC, 16'd0);
    push_cmd(OP_ALLOC, 16'd0);
    push_cmd(OP_ALLOC, 16'd0);    // queue empty, scan at the end
    push_cmd(OP_FREE, 16'd0);
    push_cmd(OP_UNUSED, 16'hFFFF);
    push_cmd(OP_ALLOC, 16'd0);
    push_cmd(OP_FREE, 16'd4);
    push_cmd(OP_ALLOC, 16'd0);
    push_cmd(OP_FORMAT, 16'hFFFF);
    push_cmd(OP_ALLOC, 16'd0);
    wait_idle();

    random_items = 0;
    phase = 1;
    while (random_items < RANDOM_ITEMS) begin
      if (phase <= 12) begin
        count_value = corner_counts[phase - 1];
      end else begin
        case ($urandom_range(0, 9))
          0:       count_value = CNT_W'($urandom_range(0, 131071));
          1, 2:    count_value = CNT_W'($urandom_range(0, 65536));
          default: count_value = CNT_W'($urandom_range(2, 400));
        endcase
      end
      write_cluster_count(count_value);
      pace = pace_t'(phase % 4);
      lim = clamp_count(count_value);
      // keep the old bitmap now and then, so a resize meets live state
      if (phase == 1 || $urandom_range(0, 2) != 0) begin
        push_cmd(OP_FORMAT, rand_cluster(0, 65535));
        random_items++;
      end
      if (phase == 1 || $urandom_range(0, 9) == 0)
        random_items += flood_free_queue(lim);
      target = $urandom_range(60, 140);
      added = 0;
      while (added < target) added += add_traffic(lim);
      random_items += added;
      wait_idle();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
